/* rtl/core/mbrtu_pkg.sv */
// Shared types and constants for the Modbus RTU request framer.
// Holds the request/frame item structs and the job descriptor passed front to back.
`default_nettype none
package mbrtu_pkg;

	localparam int MAX_WRITE_WORDS_DEF = 123;
	localparam int JOB_BYTES           = 9;
	localparam int QUEUE_DEPTH         = 2;

	localparam logic [7:0] FN_READ_LAST     = 8'd4;
	localparam logic [7:0] FN_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FN_WRITE_REG     = 8'd6;
	localparam logic [7:0] FN_WRITE_COILS   = 8'd15;
	localparam logic [7:0] FN_WRITE_REGS    = 8'd16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NODATA    = 2'd1,
		ST_BADCOUNT  = 2'd2,
		ST_BADFUNC   = 2'd3
	} status_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  slave_address;
		logic [7:0]  function_number;
		logic [15:0] start_register;
		logic [15:0] item_count;
		logic        has_write_data;
		logic [15:0] data_word;
	} req_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
		status_t    status;
	} frm_item_t;

	// One unit of back-end work: literal bytes, then optional CRC, or an error result.
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [3:0]                nbytes;
		logic                      crc_init;
		logic                      append_crc;
		logic                      is_err;
		status_t                   status;
	} job_t;

endpackage
`default_nettype wire

/* rtl/core/modbus_rtu_request_framer_unit.sv */
// Modbus RTU request framer, top level: front classifier, job queue, byte back end.
// Accepted items pass the job queue, current job and output register. One frame byte per
// cycle leaves the back end while the frame channel takes it; a header item yields 1 to 11
// items (eleven for a full write-multiple header), a data item 0 to 4 (none if ignored).
// The request side keeps accepting while the two-entry job queue has room.
// Reset (arst_n low): queue empty, no open frame, CRC at 0xFFFF, no output pending.
`default_nettype none
module modbus_rtu_request_framer_unit #(
	parameter int MAX_WRITE_WORDS = mbrtu_pkg::MAX_WRITE_WORDS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire mbrtu_pkg::req_item_t  req,
	output logic                       frm_valid,
	input  wire logic                  frm_ready,
	output mbrtu_pkg::frm_item_t       frm
);
	import mbrtu_pkg::*;

	logic  accept, push, pop, full, q_valid;
	job_t  new_job, head_job;

	assign req_ready = !full;
	assign accept    = req_valid && req_ready;

	mbrtu_front #(
		.MAX_WRITE_WORDS(MAX_WRITE_WORDS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.job    (new_job),
		.push   (push)
	);

	mbrtu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push && accept),
		.push_job (new_job),
		.pop      (pop),
		.full     (full),
		.valid    (q_valid),
		.head     (head_job)
	);

	mbrtu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_in    (head_job),
		.pop       (pop),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm)
	);

endmodule
`default_nettype wire

/* rtl/core/mbrtu_front.sv */
// Front end: accepts request items, tracks the open frame and classifies each
// item into a byte job. Depends on mbrtu_pkg.
`default_nettype none
module mbrtu_front #(
	parameter int MAX_WRITE_WORDS = mbrtu_pkg::MAX_WRITE_WORDS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire mbrtu_pkg::req_item_t req,
	output mbrtu_pkg::job_t         job,
	output logic                    push
);
	import mbrtu_pkg::*;

	localparam logic [16:0] MAX_WORDS = 17'(MAX_WRITE_WORDS);
	localparam logic [16:0] MAX_BC    = 17'(2 * MAX_WRITE_WORDS);

	logic       frame_open_q, frame_open_n;
	logic [7:0] bytes_left_q, bytes_left_n;

	logic [15:0] cnt_m1;
	logic [16:0] bc;
	logic        bc_bad;
	logic        two_first;
	logic [7:0]  left_data, left_hdr;

	always_comb begin
		cnt_m1 = req.item_count - 16'd1;
		if (req.function_number == FN_WRITE_COILS) begin
			bc = 17'({4'b0, cnt_m1[15:3]}) + 17'd1;
		end else begin
			bc = {req.item_count, 1'b0};
		end
		bc_bad = ((req.function_number == FN_WRITE_REGS) && (17'(req.item_count) > MAX_WORDS))
			|| (bc > MAX_BC) || (bc > 17'd255);
		two_first = (bc >= 17'd2);
		left_hdr  = bc[7:0] - (two_first ? 8'd2 : 8'd1);
		left_data = bytes_left_q - ((bytes_left_q >= 8'd2) ? 8'd2 : 8'd1);
	end

	always_comb begin
		job          = '0;
		push         = 1'b0;
		frame_open_n = frame_open_q;
		bytes_left_n = bytes_left_q;
		if (req.mode) begin
			if (frame_open_q && (bytes_left_q != 8'd0)) begin
				push          = 1'b1;
				job.bytes[0]  = req.data_word[15:8];
				job.bytes[1]  = req.data_word[7:0];
				job.nbytes    = (bytes_left_q >= 8'd2) ? 4'd2 : 4'd1;
				job.append_crc = (left_data == 8'd0);
				bytes_left_n  = left_data;
				frame_open_n  = (left_data != 8'd0);
			end else begin
				frame_open_n = 1'b0;
			end
		end else begin
			push         = 1'b1;
			job.crc_init = 1'b1;
			frame_open_n = 1'b0;
			bytes_left_n = 8'd0;
			job.bytes[0] = req.slave_address;
			job.bytes[1] = req.function_number;
			job.bytes[2] = req.start_register[15:8];
			job.bytes[3] = req.start_register[7:0];
			case (req.function_number) inside
				[8'd0:FN_READ_LAST]: begin
					job.bytes[4]   = req.item_count[15:8];
					job.bytes[5]   = req.item_count[7:0];
					job.nbytes     = 4'd6;
					job.append_crc = 1'b1;
				end
				FN_WRITE_COIL, FN_WRITE_REG: begin
					if (!req.has_write_data) begin
						job.is_err = 1'b1;
						job.status = ST_NODATA;
					end else if (req.item_count != 16'd1) begin
						job.is_err = 1'b1;
						job.status = ST_BADCOUNT;
					end else begin
						job.bytes[4]   = req.data_word[15:8];
						job.bytes[5]   = req.data_word[7:0];
						job.nbytes     = 4'd6;
						job.append_crc = 1'b1;
					end
				end
				FN_WRITE_COILS, FN_WRITE_REGS: begin
					if (!req.has_write_data) begin
						job.is_err = 1'b1;
						job.status = ST_NODATA;
					end else if ((req.item_count == 16'd0) || bc_bad) begin
						job.is_err = 1'b1;
						job.status = ST_BADCOUNT;
					end else begin
						job.bytes[4]   = req.item_count[15:8];
						job.bytes[5]   = req.item_count[7:0];
						job.bytes[6]   = bc[7:0];
						job.bytes[7]   = req.data_word[15:8];
						job.bytes[8]   = req.data_word[7:0];
						job.nbytes     = two_first ? 4'd9 : 4'd8;
						job.append_crc = (left_hdr == 8'd0);
						bytes_left_n   = left_hdr;
						frame_open_n   = (left_hdr != 8'd0);
					end
				end
				default: begin
					job.is_err = 1'b1;
					job.status = ST_BADFUNC;
				end
			endcase
			if (job.is_err) begin
				job.bytes = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= 8'd0;
		end else if (accept) begin
			frame_open_q <= frame_open_n;
			bytes_left_q <= bytes_left_n;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/mbrtu_queue.sv */
// Short job queue between the front and back ends.
// Depends on mbrtu_pkg for the job type and depth.
`default_nettype none
module mbrtu_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mbrtu_pkg::job_t  push_job,
	input  wire logic             pop,
	output logic                  full,
	output logic                  valid,
	output mbrtu_pkg::job_t       head
);
	import mbrtu_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

	job_t          slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/mbrtu_back.sv */
// Back end: plays out one job a byte per cycle unless the output stalls, folds each byte into the
// CRC-16 and appends it. Output register toward the frame channel. Depends on mbrtu_pkg.
`default_nettype none
module mbrtu_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 job_valid,
	input  wire mbrtu_pkg::job_t      job_in,
	output logic                      pop,
	output logic                      frm_valid,
	input  wire logic                 frm_ready,
	output mbrtu_pkg::frm_item_t      frm
);
	import mbrtu_pkg::*;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	job_t        cur_q;
	logic        cur_valid_q;
	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	frm_item_t   out_q;

	logic [3:0]  total;
	logic        step, last, is_data;
	frm_item_t   emit;

	always_comb begin
		total   = cur_q.is_err ? 4'd1 : (cur_q.nbytes + (cur_q.append_crc ? 4'd2 : 4'd0));
		step    = cur_valid_q && (!out_valid_q || frm_ready);
		last    = (idx_q == total - 4'd1);
		is_data = !cur_q.is_err && (idx_q < cur_q.nbytes);
		pop     = job_valid && (!cur_valid_q || (step && last));
		emit    = '0;
		if (cur_q.is_err) begin
			emit.frame_end = 1'b1;
			emit.status    = cur_q.status;
		end else if (is_data) begin
			emit.frame_byte = cur_q.bytes[idx_q];
		end else if (idx_q == cur_q.nbytes) begin
			emit.frame_byte = crc_q[7:0];
		end else begin
			emit.frame_byte = crc_q[15:8];
			emit.frame_end  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 4'd0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 4'd0;
			end else if (step) begin
				cur_valid_q <= !last;
				idx_q       <= idx_q + 4'd1;
			end
			// a new frame restarts the CRC even if the old frame was cut short
			if (pop && job_in.crc_init) begin
				crc_q <= CRC_INIT;
			end else if (step && is_data) begin
				crc_q <= crc_fold(crc_q, emit.frame_byte);
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (frm_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= job_in;
		end
		if (step) begin
			out_q <= emit;
		end
	end

	assign frm_valid = out_valid_q;
	assign frm       = out_q;

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for modbus_rtu_request_framer_unit: directed and random request items.
// Predicts each frame byte, the CRC-16 tail and the error results; compares them in order.
// Depends on mbrtu_pkg and the framer RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mbrtu_pkg::*;

	localparam int MAX_WORDS      = MAX_WRITE_WORDS_DEF;
	// largest coil count whose byte count still fits 2*MAX_WORDS bytes
	localparam int COIL_COUNT_MAX = 16 * MAX_WORDS;
	localparam int DRAIN_CYCLES   = 32;
	localparam int RANDOM_ITEMS   = 480;

	localparam logic MODE_HEADER = 1'b0;
	localparam logic MODE_DATA   = 1'b1;

	localparam logic [7:0] FN_READ_FIRST   = 8'd0;
	localparam logic [7:0] FN_UNSUP_LOW    = 8'd7;
	localparam logic [7:0] FN_UNSUP_MID    = 8'd14;
	localparam logic [7:0] FN_UNSUP_HIGH   = 8'd17;
	localparam logic [7:0] FN_UNSUP_TOP    = 8'd255;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_item_t   req       = '0;
	logic        frm_valid;
	logic        frm_ready = 1'b0;
	frm_item_t   frm;

	// predictor state
	logic [15:0] crc_acc       = CRC_INIT;
	logic [7:0]  data_left     = 8'd0;
	bit          frame_pending = 1'b0;
	frm_item_t   frame_expect[$];
	frm_item_t   frame_want;

	int mismatch_count = 0;
	int items_sent     = 0;
	int stray_items    = 0;
	int bytes_checked  = 0;
	int frames_closed  = 0;
	int error_results  = 0;
	int burst_left     = 0;
	int gap_left       = 0;
	int rx_cycle       = 0;
	int rx_pattern     = 0;

	modbus_rtu_request_framer_unit #(
		.MAX_WRITE_WORDS(MAX_WORDS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.frm_valid(frm_valid),
		.frm_ready(frm_ready),
		.frm      (frm)
	);

	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: periodically switch among four stall patterns
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0) begin
			rx_pattern <= $urandom_range(0, 3);
		end
		case (rx_pattern)
			0: frm_ready <= 1'b1;
			1: frm_ready <= ($urandom_range(0, 3) != 0);
			2: frm_ready <= ($urandom_range(0, 3) == 0);
			default: frm_ready <= rx_cycle[2];
		endcase
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 30) begin
			$display("MISMATCH at %0t ns: %s", $time, msg);
		end
	endtask

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] acc;
		acc = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		end
		return acc;
	endfunction

	function automatic void expect_byte(input logic [7:0] b);
		crc_acc = crc_step(crc_acc, b);
		frame_expect.push_back('{frame_byte: b, frame_end: 1'b0, status: ST_OK});
	endfunction

	function automatic void expect_crc();
		frame_expect.push_back('{frame_byte: crc_acc[7:0], frame_end: 1'b0, status: ST_OK});
		frame_expect.push_back('{frame_byte: crc_acc[15:8], frame_end: 1'b1, status: ST_OK});
	endfunction

	function automatic void expect_error(input status_t st);
		frame_expect.push_back('{frame_byte: 8'h00, frame_end: 1'b1, status: st});
	endfunction

	function automatic int coil_or_reg_bytes(input logic [7:0] fn, input int cnt);
		return (fn == FN_WRITE_COILS) ? ((cnt - 1) / 8 + 1) : cnt * 2;
	endfunction

	function automatic void predict_frame(input req_item_t r);
		int byte_cnt;
		int first;
		if (r.mode == MODE_DATA) begin
			if (!frame_pending || data_left == 0) begin
				frame_pending = 1'b0;
				stray_items++;
				return;
			end
			expect_byte(r.data_word[15:8]);
			if (data_left >= 2) begin
				expect_byte(r.data_word[7:0]);
				data_left = data_left - 8'd2;
			end else begin
				data_left = data_left - 8'd1;
			end
			if (data_left == 0) begin
				frame_pending = 1'b0;
				expect_crc();
			end
			return;
		end
		// a header drops whatever frame was open
		frame_pending = 1'b0;
		data_left     = 8'd0;
		crc_acc       = CRC_INIT;
		if (r.function_number <= FN_READ_LAST) begin
			expect_byte(r.slave_address);
			expect_byte(r.function_number);
			expect_byte(r.start_register[15:8]);
			expect_byte(r.start_register[7:0]);
			expect_byte(r.item_count[15:8]);
			expect_byte(r.item_count[7:0]);
			expect_crc();
		end else if (r.function_number == FN_WRITE_COIL || r.function_number == FN_WRITE_REG) begin
			if (!r.has_write_data) begin
				expect_error(ST_NODATA);
			end else if (r.item_count != 16'd1) begin
				expect_error(ST_BADCOUNT);
			end else begin
				expect_byte(r.slave_address);
				expect_byte(r.function_number);
				expect_byte(r.start_register[15:8]);
				expect_byte(r.start_register[7:0]);
				expect_byte(r.data_word[15:8]);
				expect_byte(r.data_word[7:0]);
				expect_crc();
			end
		end else if (r.function_number == FN_WRITE_COILS || r.function_number == FN_WRITE_REGS) begin
			byte_cnt = (r.item_count == 0) ? 0 : coil_or_reg_bytes(r.function_number, r.item_count);
			if (!r.has_write_data) begin
				expect_error(ST_NODATA);
			end else if (r.item_count == 16'd0) begin
				expect_error(ST_BADCOUNT);
			end else if (r.function_number == FN_WRITE_REGS && r.item_count > MAX_WORDS) begin
				expect_error(ST_BADCOUNT);
			end else if (byte_cnt > 2 * MAX_WORDS || byte_cnt > 255) begin
				expect_error(ST_BADCOUNT);
			end else begin
				expect_byte(r.slave_address);
				expect_byte(r.function_number);
				expect_byte(r.start_register[15:8]);
				expect_byte(r.start_register[7:0]);
				expect_byte(r.item_count[15:8]);
				expect_byte(r.item_count[7:0]);
				expect_byte(byte_cnt[7:0]);
				first = (byte_cnt >= 2) ? 2 : 1;
				expect_byte(r.data_word[15:8]);
				if (first == 2) begin
					expect_byte(r.data_word[7:0]);
				end
				data_left = 8'(byte_cnt - first);
				if (data_left == 0) begin
					expect_crc();
				end else begin
					frame_pending = 1'b1;
				end
			end
		end else begin
			expect_error(ST_BADFUNC);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && frm_valid && frm_ready) begin
			if (frame_expect.size() == 0) begin
				report_mismatch($sformatf("unexpected item byte %02h end %0b status %0d",
					frm.frame_byte, frm.frame_end, frm.status));
			end else begin
				frame_want = frame_expect.pop_front();
				if (frm.frame_byte !== frame_want.frame_byte) begin
					report_mismatch($sformatf("frame_byte %02h, want %02h",
						frm.frame_byte, frame_want.frame_byte));
				end
				if (frm.frame_end !== frame_want.frame_end) begin
					report_mismatch($sformatf("frame_end %0b, want %0b",
						frm.frame_end, frame_want.frame_end));
				end
				if (frm.status !== frame_want.status) begin
					report_mismatch($sformatf("status %0d, want %0d",
						frm.status, frame_want.status));
				end
				bytes_checked++;
				if (frame_want.frame_end && frame_want.status == ST_OK) begin
					frames_closed++;
				end
				if (frame_want.status != ST_OK) begin
					error_results++;
				end
			end
		end
	end

	// hold valid across bursts; drop it only for a gap
	task automatic send_request(input req_item_t item);
		if (gap_left > 0) begin
			req_valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_frame(item);
		items_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 15) == 0) begin
				gap_left = 24;
			end else begin
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic release_sender();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_frames_drained();
		release_sender();
		while (frame_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic req_item_t make_header(input logic [7:0] fn, input logic [15:0] cnt,
			input logic has);
		req_item_t r;
		r.mode            = MODE_HEADER;
		r.slave_address   = 8'($urandom);
		r.function_number = fn;
		r.start_register  = 16'($urandom);
		r.item_count      = cnt;
		r.has_write_data  = has;
		r.data_word       = 16'($urandom);
		return r;
	endfunction

	function automatic req_item_t make_data_item(input logic [15:0] word);
		req_item_t r;
		r                 = make_header(8'($urandom), 16'($urandom), 1'($urandom));
		r.mode            = MODE_DATA;
		r.data_word       = word;
		return r;
	endfunction

	// header plus up to keep data items; fewer than needed leaves the frame open
	task automatic write_multiple(input logic [7:0] fn, input int cnt, input int keep);
		int byte_cnt;
		int n;
		byte_cnt = coil_or_reg_bytes(fn, cnt);
		n = (byte_cnt - ((byte_cnt >= 2) ? 2 : 1) + 1) / 2;
		if (keep < n) begin
			n = keep;
		end
		send_request(make_header(fn, 16'(cnt), 1'b1));
		for (int i = 0; i < n; i++) begin
			send_request(make_data_item(16'($urandom)));
		end
	endtask

	task automatic test_read_requests();
		req_item_t r;
		r = make_header(FN_READ_FIRST, 16'h0000, 1'b0);
		r.slave_address  = 8'h00;
		r.start_register = 16'h0000;
		send_request(r);
		r = make_header(FN_READ_LAST, 16'hFFFF, 1'b1);
		r.slave_address  = 8'hFF;
		r.start_register = 16'hFFFF;
		send_request(r);
	endtask

	task automatic test_single_writes();
		req_item_t r;
		r = make_header(FN_WRITE_COIL, 16'd1, 1'b1);
		r.data_word = 16'hFFFF;
		send_request(r);
		r = make_header(FN_WRITE_REG, 16'd1, 1'b1);
		r.data_word = 16'h0000;
		send_request(r);
	endtask

	task automatic test_write_multiple();
		req_item_t r;
		// single-byte and single-word bodies close with the header
		send_request(make_header(FN_WRITE_COILS, 16'd1, 1'b1));
		send_request(make_header(FN_WRITE_REGS, 16'd1, 1'b1));
		r = make_header(FN_WRITE_REGS, 16'd2, 1'b1);
		r.data_word = 16'h0000;
		send_request(r);
		send_request(make_data_item(16'hFFFF));
		// three data bytes: last word sends its high byte only
		write_multiple(FN_WRITE_COILS, 17, 1);
	endtask

	task automatic test_request_errors();
		send_request(make_header(FN_WRITE_COIL, 16'd1, 1'b0));
		send_request(make_header(FN_WRITE_REGS, 16'd0, 1'b0));
		send_request(make_header(FN_WRITE_REG, 16'd0, 1'b1));
		send_request(make_header(FN_WRITE_REGS, 16'd0, 1'b1));
		send_request(make_header(FN_WRITE_REGS, 16'(MAX_WORDS + 1), 1'b1));
		send_request(make_header(FN_WRITE_COILS, 16'(COIL_COUNT_MAX + 1), 1'b1));
		send_request(make_header(FN_WRITE_COILS, 16'hFFFF, 1'b1));
		send_request(make_header(FN_UNSUP_LOW, 16'd1, 1'b1));
		send_request(make_header(FN_UNSUP_MID, 16'd1, 1'b1));
		send_request(make_header(FN_UNSUP_HIGH, 16'd1, 1'b1));
		send_request(make_header(FN_UNSUP_TOP, 16'd1, 1'b1));
	endtask

	task automatic test_interrupted_frames();
		send_request(make_data_item(16'($urandom)));
		// drop an open frame with a new header, then offer a data item to nothing
		write_multiple(FN_WRITE_REGS, 3, 1);
		send_request(make_header(8'($urandom_range(FN_READ_FIRST, FN_READ_LAST)),
			16'($urandom), 1'b0));
		send_request(make_data_item(16'($urandom)));
	endtask

	task automatic send_error_request();
		logic [7:0] fn;
		int         cnt;
		case ($urandom_range(0, 4))
			0: begin
				case ($urandom_range(0, 3))
					0: fn = FN_WRITE_COIL;
					1: fn = FN_WRITE_REG;
					2: fn = FN_WRITE_COILS;
					default: fn = FN_WRITE_REGS;
				endcase
				send_request(make_header(fn, 16'($urandom), 1'b0));
			end
			1: begin
				cnt = $urandom_range(0, 65535);
				if (cnt == 1) begin
					cnt = 0;
				end
				fn = $urandom_range(0, 1) ? FN_WRITE_COIL : FN_WRITE_REG;
				send_request(make_header(fn, 16'(cnt), 1'b1));
			end
			2: begin
				cnt = $urandom_range(0, 3) ? $urandom_range(MAX_WORDS + 1, 65535) : 0;
				send_request(make_header(FN_WRITE_REGS, 16'(cnt), 1'b1));
			end
			3: begin
				cnt = $urandom_range(0, 3) ? $urandom_range(COIL_COUNT_MAX + 1, 65535) : 0;
				send_request(make_header(FN_WRITE_COILS, 16'(cnt), 1'b1));
			end
			default: begin
				fn = $urandom_range(0, 1) ? 8'($urandom_range(FN_UNSUP_LOW, FN_UNSUP_MID))
					: 8'($urandom_range(FN_UNSUP_HIGH, FN_UNSUP_TOP));
				send_request(make_header(fn, 16'($urandom), 1'($urandom)));
			end
		endcase
	endtask

	task automatic test_random_traffic();
		int         stop_at;
		int         pick;
		int         cnt;
		int         r;
		logic [7:0] fn;
		stop_at = items_sent - stray_items + RANDOM_ITEMS;
		while (items_sent - stray_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 28) begin
				send_request(make_header(8'($urandom_range(FN_READ_FIRST, FN_READ_LAST)),
					16'($urandom), 1'($urandom)));
			end else if (pick < 40) begin
				fn = $urandom_range(0, 1) ? FN_WRITE_COIL : FN_WRITE_REG;
				send_request(make_header(fn, ($urandom_range(0, 9) != 0) ? 16'd1 : 16'($urandom),
					($urandom_range(0, 9) != 0)));
			end else if (pick < 83) begin
				fn = $urandom_range(0, 1) ? FN_WRITE_COILS : FN_WRITE_REGS;
				r  = $urandom_range(0, 49);
				if (fn == FN_WRITE_REGS) begin
					cnt = (r == 0) ? MAX_WORDS : (r < 5) ? $urandom_range(1, MAX_WORDS)
						: $urandom_range(1, 8);
				end else begin
					cnt = (r == 0) ? COIL_COUNT_MAX : (r < 5) ? $urandom_range(1, COIL_COUNT_MAX)
						: $urandom_range(1, 64);
				end
				// most sequences complete; the rest keep at most three data items and may break off early
				write_multiple(fn, cnt, (pick < 75) ? 255 : $urandom_range(0, 3));
			end else if (pick < 93) begin
				send_error_request();
			end else begin
				send_request(make_data_item(16'($urandom)));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_read_requests();
		wait_frames_drained();
		test_single_writes();
		wait_frames_drained();
		test_write_multiple();
		wait_frames_drained();
		test_request_errors();
		wait_frames_drained();
		test_interrupted_frames();
		wait_frames_drained();
		test_random_traffic();
		wait_frames_drained();
		$display("Run covered %0d request items (%0d ignored data items) and checked %0d",
			items_sent, stray_items, bytes_checked);
		$display("output items: %0d complete frames with CRC, %0d error results.",
			frames_closed, error_results);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/mbrtu_pkg.sv
rtl/core/mbrtu_front.sv
rtl/core/mbrtu_queue.sv
rtl/core/mbrtu_back.sv
rtl/core/modbus_rtu_request_framer_unit.sv
bench/tb.sv
